// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define LLINT_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define LLINT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LLINT_ASSERT(lbl, ante, cons, msg)
`define LLINT_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/llint_pkg.sv =====
// ----------------------------------------------------------------------------
// llint_pkg
// Widths, saturation limits and item types of the line intersection block.
// ----------------------------------------------------------------------------
package llint_pkg;

  localparam int COORD_W = 16;
  localparam int RES_W   = 32;

  // Exact intermediate widths; nothing is rounded before the divide.
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 1;
  localparam int CPROD_W = DIFF_W + COORD_W;
  localparam int C_W     = CPROD_W + 1;
  localparam int NPROD_W = DIFF_W + C_W;
  localparam int NUM_W   = NPROD_W + 1;
  localparam int CMP_W   = (DET_W + RES_W > NUM_W) ? DET_W + RES_W : NUM_W;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_W-1:0] first_start_x;
    logic signed [COORD_W-1:0] first_start_y;
    logic signed [COORD_W-1:0] first_end_x;
    logic signed [COORD_W-1:0] first_end_y;
    logic signed [COORD_W-1:0] second_start_x;
    logic signed [COORD_W-1:0] second_start_y;
    logic signed [COORD_W-1:0] second_end_x;
    logic signed [COORD_W-1:0] second_end_y;
  } llint_in_t;

  typedef struct packed {
    logic signed [RES_W-1:0] cross_x;
    logic signed [RES_W-1:0] cross_y;
    logic                    parallel;
    logic                    overflow;
  } llint_out_t;

  typedef struct packed {
    logic signed [RES_W-1:0] coord;
    logic                    ovf;
    logic                    zero;
  } llint_div_t;

endpackage

// ===== rtl/llint_in_if.sv =====
// ----------------------------------------------------------------------------
// llint_in_if
// Input channel: one item holds the two point pairs of both lines.
// ----------------------------------------------------------------------------
interface llint_in_if;
  import llint_pkg::*;

  logic      valid;
  logic      ready;
  llint_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/llint_out_if.sv =====
// ----------------------------------------------------------------------------
// llint_out_if
// Output channel: one item holds the crossing point and its flags.
// ----------------------------------------------------------------------------
interface llint_out_if;
  import llint_pkg::*;

  logic       valid;
  logic       ready;
  llint_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/llint_front.sv =====
// ----------------------------------------------------------------------------
// llint_front
// Five-stage front end: line coefficients, determinant and both numerators.
// ----------------------------------------------------------------------------
module llint_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  logic                                valid_i,
  input  llint_pkg::llint_in_t                data_i,
  output logic                                valid_o,
  output logic signed [llint_pkg::NUM_W-1:0]  num_x_o,
  output logic signed [llint_pkg::NUM_W-1:0]  num_y_o,
  output logic signed [llint_pkg::DET_W-1:0]  det_o
);
  import llint_pkg::*;

  logic [4:0] vld_q;

  // Stage 1: coefficients and anchor points.
  logic signed [DIFF_W-1:0]  a1_q, b1_q, a1s_q, b1s_q;
  logic signed [COORD_W-1:0] x1_q, y1_q, x3_q, y3_q;
  // Stage 2: first products.
  logic signed [PROD_W-1:0]  p_ab1_q, p_a1b_q;
  logic signed [CPROD_W-1:0] p_ax_q, p_by_q, p_a1x_q, p_b1y_q;
  logic signed [DIFF_W-1:0]  a2_q, b2_q, a2s_q, b2s_q;
  // Stage 3: determinant and right-hand sides.
  logic signed [DET_W-1:0]   det3_q;
  logic signed [C_W-1:0]     c_q, c1_q;
  logic signed [DIFF_W-1:0]  a3_q, b3_q, a3s_q, b3s_q;
  // Stage 4: numerator products.
  logic signed [NPROD_W-1:0] m_b1c_q, m_bc1_q, m_ac1_q, m_a1c_q;
  logic signed [DET_W-1:0]   det4_q;
  // Stage 5: numerators.
  logic signed [NUM_W-1:0]   num_x_q, num_y_q;
  logic signed [DET_W-1:0]   det5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a1_q  <= DIFF_W'(data_i.first_end_y) - DIFF_W'(data_i.first_start_y);
      b1_q  <= DIFF_W'(data_i.first_start_x) - DIFF_W'(data_i.first_end_x);
      a1s_q <= DIFF_W'(data_i.second_end_y) - DIFF_W'(data_i.second_start_y);
      b1s_q <= DIFF_W'(data_i.second_start_x) - DIFF_W'(data_i.second_end_x);
      x1_q  <= data_i.first_start_x;
      y1_q  <= data_i.first_start_y;
      x3_q  <= data_i.second_start_x;
      y3_q  <= data_i.second_start_y;

      p_ab1_q <= PROD_W'(a1_q) * PROD_W'(b1s_q);
      p_a1b_q <= PROD_W'(a1s_q) * PROD_W'(b1_q);
      p_ax_q  <= CPROD_W'(a1_q) * CPROD_W'(x1_q);
      p_by_q  <= CPROD_W'(b1_q) * CPROD_W'(y1_q);
      p_a1x_q <= CPROD_W'(a1s_q) * CPROD_W'(x3_q);
      p_b1y_q <= CPROD_W'(b1s_q) * CPROD_W'(y3_q);
      a2_q    <= a1_q;
      b2_q    <= b1_q;
      a2s_q   <= a1s_q;
      b2s_q   <= b1s_q;

      det3_q <= DET_W'(p_ab1_q) - DET_W'(p_a1b_q);
      c_q    <= C_W'(p_ax_q) + C_W'(p_by_q);
      c1_q   <= C_W'(p_a1x_q) + C_W'(p_b1y_q);
      a3_q   <= a2_q;
      b3_q   <= b2_q;
      a3s_q  <= a2s_q;
      b3s_q  <= b2s_q;

      m_b1c_q <= NPROD_W'(b3s_q) * NPROD_W'(c_q);
      m_bc1_q <= NPROD_W'(b3_q) * NPROD_W'(c1_q);
      m_ac1_q <= NPROD_W'(a3_q) * NPROD_W'(c1_q);
      m_a1c_q <= NPROD_W'(a3s_q) * NPROD_W'(c_q);
      det4_q  <= det3_q;

      num_x_q <= NUM_W'(m_b1c_q) - NUM_W'(m_bc1_q);
      num_y_q <= NUM_W'(m_ac1_q) - NUM_W'(m_a1c_q);
      det5_q  <= det4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign num_x_o = num_x_q;
  assign num_y_o = num_y_q;
  assign det_o   = det5_q;

endmodule

// ===== rtl/llint_div.sv =====
// ----------------------------------------------------------------------------
// llint_div
// Pipelined restoring divider with truncation toward zero and saturation.
// One quotient bit per stage; a range check up front flags quotients that
// cannot fit the result width.
// ----------------------------------------------------------------------------
module llint_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               adv_i,
  input  logic                               valid_i,
  input  logic signed [llint_pkg::NUM_W-1:0] num_i,
  input  logic signed [llint_pkg::DET_W-1:0] det_i,
  output logic                               valid_o,
  output llint_pkg::llint_div_t              res_o
);
  import llint_pkg::*;

  // Magnitude stage.
  logic             mv_q;
  logic [NUM_W-1:0] mn_q;
  logic [DET_W-1:0] md_q;
  logic             mneg_q;

  // Range-check output and one entry per quotient bit stage.
  logic             vld_q  [0:RES_W];
  logic [NUM_W-1:0] rem_q  [0:RES_W];
  logic [DET_W-1:0] dvs_q  [0:RES_W];
  logic [RES_W-1:0] quo_q  [0:RES_W];
  logic             neg_q  [0:RES_W];
  logic             big_q  [0:RES_W];
  logic             zero_q [0:RES_W];

  logic       out_v_q;
  llint_div_t out_q;
  llint_div_t out_d;
  logic       ovf_pos;
  logic       ovf_neg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q      <= 1'b0;
      vld_q[0]  <= 1'b0;
      out_v_q   <= 1'b0;
    end else if (adv_i) begin
      mv_q      <= valid_i;
      vld_q[0]  <= mv_q;
      out_v_q   <= vld_q[RES_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mn_q   <= num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);
      md_q   <= det_i[DET_W-1] ? DET_W'(-det_i) : DET_W'(det_i);
      mneg_q <= num_i[NUM_W-1] ^ det_i[DET_W-1];

      // A quotient of 2^RES_W or more saturates whatever its sign.
      big_q[0]  <= CMP_W'(mn_q) >= (CMP_W'(md_q) << RES_W);
      zero_q[0] <= (md_q == '0);
      rem_q[0]  <= mn_q;
      dvs_q[0]  <= md_q;
      quo_q[0]  <= '0;
      neg_q[0]  <= mneg_q;
    end
  end

  for (genvar k = 0; k < RES_W; k++) begin : g_bit
    localparam int Sh = RES_W - 1 - k;

    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] dsh;
    logic             fit;
    logic [RES_W-1:0] quo_d;

    always_comb begin
      rem_ext    = CMP_W'(rem_q[k]);
      dsh        = CMP_W'(dvs_q[k]) << Sh;
      fit        = rem_ext >= dsh;
      quo_d      = quo_q[k];
      quo_d[Sh]  = fit;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k+1]  <= fit ? NUM_W'(rem_ext - dsh) : rem_q[k];
        dvs_q[k+1]  <= dvs_q[k];
        quo_q[k+1]  <= quo_d;
        neg_q[k+1]  <= neg_q[k];
        big_q[k+1]  <= big_q[k];
        zero_q[k+1] <= zero_q[k];
      end
    end
  end

  // A negative result may reach the magnitude of the most negative value.
  assign ovf_pos = big_q[RES_W] || quo_q[RES_W][RES_W-1];
  assign ovf_neg = big_q[RES_W] ||
                   (quo_q[RES_W][RES_W-1] && (quo_q[RES_W][RES_W-2:0] != '0));

  always_comb begin
    out_d.zero = zero_q[RES_W];
    if (zero_q[RES_W]) begin
      out_d.coord = '0;
      out_d.ovf   = 1'b0;
    end else if (neg_q[RES_W]) begin
      out_d.ovf   = ovf_neg;
      out_d.coord = ovf_neg ? RES_MIN : -$signed(quo_q[RES_W]);
    end else begin
      out_d.ovf   = ovf_pos;
      out_d.coord = ovf_pos ? RES_MAX : $signed(quo_q[RES_W]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_v_q;
  assign res_o   = out_q;

endmodule

// ===== rtl/llint_skid.sv =====
// ----------------------------------------------------------------------------
// llint_skid
// Two-entry output buffer that decouples the pipeline from the receiver.
// ----------------------------------------------------------------------------
module llint_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  llint_pkg::llint_out_t data_i,
  output logic                  adv_o,
  llint_out_if.source           out_o
);
  import llint_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  llint_out_t slot0_q, slot0_d;
  llint_out_t slot1_q, slot1_d;
  logic       push;
  logic       pop;

  // The pipeline moves unless the buffer is full and an item waits at its end.
  assign adv_o = (cnt_q != 2'd2) || !valid_i;
  assign push  = adv_o && valid_i;
  assign pop   = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    case ({push, pop})
      2'b10: begin
        if (cnt_q == 2'd0) begin
          slot0_d = data_i;
        end else begin
          slot1_d = data_i;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        slot0_d = slot1_q;
        cnt_d   = cnt_q - 2'd1;
      end
      2'b11: begin
        // A push only happens with at most one item held.
        slot0_d = data_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = slot0_q;

endmodule

// ===== rtl/line_line_intersection.sv =====
// ----------------------------------------------------------------------------
// line_line_intersection
// Crossing point of two infinite lines by Cramer's rule, Q12.4 in, Q28.4 out.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_i (valid/ready) as two point pairs, one pair per line,
// and leave on out_o as the crossing point with parallel and overflow flags.
// Every input item yields exactly one output item, in order.
// From the accepting edge to the earliest edge at which the result can be
// taken, an item passes five front stages (coefficients, products,
// determinant, numerator products, numerators), two divider setup stages,
// one stage per quotient bit (32), a saturation stage and the output buffer.
// Throughput is one item per cycle while the output buffer is not full; the
// quotient-bit stages of the two dividers set the depth, not the rate.
// Reset clears all valid bits and the output buffer; no item is in flight
// afterwards and in_i.ready is high.
// When the receiver stalls, the two-entry output buffer fills first; only
// then does the pipeline freeze and in_i.ready drop. Bubbles at the end of
// the pipeline are squeezed out while it is stalled.
// ----------------------------------------------------------------------------
module line_line_intersection (
  input  logic        clk_i,
  input  logic        rst_ni,
  llint_in_if.sink    in_i,
  llint_out_if.source out_o
);
  import llint_pkg::*;

  `include "assert_macros.svh"

  logic                    adv;
  logic                    front_v;
  logic signed [NUM_W-1:0] num_x;
  logic signed [NUM_W-1:0] num_y;
  logic signed [DET_W-1:0] det;
  logic                    vx;
  logic                    vy;
  llint_div_t              rx;
  llint_div_t              ry;
  llint_out_t              res;

  assign in_i.ready = adv;

  llint_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_i.valid),
    .data_i  (in_i.data),
    .valid_o (front_v),
    .num_x_o (num_x),
    .num_y_o (num_y),
    .det_o   (det)
  );

  llint_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_v),
    .num_i   (num_x),
    .det_i   (det),
    .valid_o (vx),
    .res_o   (rx)
  );

  llint_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (front_v),
    .num_i   (num_y),
    .det_i   (det),
    .valid_o (vy),
    .res_o   (ry)
  );

  always_comb begin
    res.cross_x  = rx.coord;
    res.cross_y  = ry.coord;
    res.parallel = rx.zero;
    res.overflow = rx.ovf || ry.ovf;
  end

  llint_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vx),
    .data_i  (res),
    .adv_o   (adv),
    .out_o   (out_o)
  );

  // Both dividers run in lockstep on the same determinant.
  `LLINT_ASSERT(a_lanes_aligned, vx || vy, vx == vy && rx.zero == ry.zero, "divider lanes out of step")
  // A parallel result carries zero coordinates and no overflow.
  `LLINT_ASSERT(a_parallel_clean, out_o.valid && out_o.data.parallel, !out_o.data.overflow && out_o.data.cross_x == '0 && out_o.data.cross_y == '0, "parallel result not cleared")
  // The pipeline only freezes while a finished item waits at its end.
  `LLINT_ASSERT(a_stall_cause, !adv, vx && out_o.valid, "pipeline stalled without a waiting item")
  // A full buffer still has an item to offer in the next cycle.
  `LLINT_ASSERT_NXT(a_stall_keeps_out, !adv, out_o.valid, "output buffer drained while full")

endmodule

// ===== tb/sv/crossing_check.sv =====
// ----------------------------------------------------------------------------
// crossing_check
// Watches both channels of the line intersection block, computes the
// expected crossing point of every accepted item and compares each result
// item with the oldest pending expectation, field by field.
// ----------------------------------------------------------------------------
module crossing_check (
  input  logic clk_i,
  input  logic rst_ni,
  llint_in_if  lines_mon,
  llint_out_if cross_mon,
  output int   fail_count_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import llint_pkg::*;

  llint_out_t expected_crossings[$];
  llint_out_t head;
  int         fail_count   = 0;
  int         result_index = 0;
  int         outstanding  = 0;

  assign fail_count_o  = fail_count;
  assign outstanding_o = outstanding;

  // Returns {saturated, value}.
  function automatic logic [RES_W:0] clamp_quotient(input longint q);
    if (q > longint'(RES_MAX)) return {1'b1, RES_MAX};
    if (q < longint'(RES_MIN)) return {1'b1, RES_MIN};
    return {1'b0, q[RES_W-1:0]};
  endfunction

  function automatic llint_out_t predict_crossing(input llint_in_t p);
    longint           x1, y1, x2, y2, x3, y3, x4, y4;
    longint           a, b, a1, b1, det, c, c1;
    logic [RES_W:0]   qx, qy;
    llint_out_t       r;
    x1 = $signed(p.first_start_x);
    y1 = $signed(p.first_start_y);
    x2 = $signed(p.first_end_x);
    y2 = $signed(p.first_end_y);
    x3 = $signed(p.second_start_x);
    y3 = $signed(p.second_start_y);
    x4 = $signed(p.second_end_x);
    y4 = $signed(p.second_end_y);
    a   = y2 - y1;
    b   = x1 - x2;
    a1  = y4 - y3;
    b1  = x3 - x4;
    det = a * b1 - a1 * b;
    r   = '0;
    if (det == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    c  = a * x1 + b * y1;
    c1 = a1 * x3 + b1 * y3;
    // The numerators stay below 2^53, so 64-bit division is exact and
    // truncates toward zero as the block does.
    qx = clamp_quotient((b1 * c - b * c1) / det);
    qy = clamp_quotient((a * c1 - a1 * c) / det);
    r.cross_x  = qx[RES_W-1:0];
    r.cross_y  = qy[RES_W-1:0];
    r.overflow = qx[RES_W] | qy[RES_W];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] result %0d: %s got %0d, expected %0d",
             $time, result_index, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (lines_mon.valid && lines_mon.ready) begin
        expected_crossings.push_back(predict_crossing(lines_mon.data));
      end
      if (cross_mon.valid && cross_mon.ready) begin
        if (expected_crossings.size() == 0) begin
          report_mismatch("unexpected result item, cross_x", cross_mon.data.cross_x, 0);
        end else begin
          head = expected_crossings.pop_front();
          if (cross_mon.data.cross_x !== head.cross_x)
            report_mismatch("cross_x", cross_mon.data.cross_x, head.cross_x);
          if (cross_mon.data.cross_y !== head.cross_y)
            report_mismatch("cross_y", cross_mon.data.cross_y, head.cross_y);
          if (cross_mon.data.parallel !== head.parallel)
            report_mismatch("parallel", cross_mon.data.parallel, head.parallel);
          if (cross_mon.data.overflow !== head.overflow)
            report_mismatch("overflow", cross_mon.data.overflow, head.overflow);
        end
        result_index++;
      end
      outstanding <= expected_crossings.size();
    end
  end

endmodule

// ===== tb/sv/line_line_intersection_tb.sv =====
// ----------------------------------------------------------------------------
// line_line_intersection_tb
// Drives line pairs into the intersection block with random gaps and
// receiver stalls: directed corner cases first, then random pairs shaped
// toward parallel, near-parallel, degenerate and extreme lines. The
// crossing_check module does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module line_line_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import llint_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int IDLE_PCT       = 25;
  localparam int CALM_FIRST     = 400;
  localparam int CALM_LAST      = 650;
  // The tail leaves room beyond the pipeline latency.
  localparam int TAIL_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i;
  logic rst_ni;
  int   items_sent  = 0;
  int   idle_cycles = 0;
  int   fail_count;
  int   outstanding;

  llint_in_if  lines_ch ();
  llint_out_if cross_ch ();

  line_line_intersection dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (lines_ch),
    .out_o  (cross_ch)
  );

  crossing_check crossing_check_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lines_mon     (lines_ch),
    .cross_mon     (cross_ch),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Neither side idles while the calm stretch of items is under way.
  function automatic bit calm_phase();
    return items_sent >= CALM_FIRST && items_sent < CALM_LAST;
  endfunction

  function automatic int span(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(0, 6))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      5:       return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic llint_in_t pack_lines(input int x1, input int y1, input int x2,
                                           input int y2, input int x3, input int y3,
                                           input int x4, input int y4);
    llint_in_t item;
    item.first_start_x  = 16'(x1);
    item.first_start_y  = 16'(y1);
    item.first_end_x    = 16'(x2);
    item.first_end_y    = 16'(y2);
    item.second_start_x = 16'(x3);
    item.second_start_y = 16'(y3);
    item.second_end_x   = 16'(x4);
    item.second_end_y   = 16'(y4);
    return item;
  endfunction

  function automatic llint_in_t random_lines();
    int        sel, x1, y1, dx, dy, x3, y3, ex, ey, k, m;
    llint_in_t item;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      item = {$urandom(), $urandom(), $urandom(), $urandom()};
    end else if (sel < 45) begin
      item = pack_lines(span(-64, 64), span(-64, 64), span(-64, 64), span(-64, 64),
                        span(-64, 64), span(-64, 64), span(-64, 64), span(-64, 64));
    end else if (sel < 60) begin
      // Parallel lines, coincident about a third of the time.
      x1 = span(-8000, 8000);
      y1 = span(-8000, 8000);
      dx = span(-8000, 8000);
      dy = span(-8000, 8000);
      k  = span(1, 2) * (($urandom_range(0, 1) != 0) ? 1 : -1);
      if ($urandom_range(0, 2) == 0) begin
        m  = span(-1, 1);
        x3 = x1 + m * dx;
        y3 = y1 + m * dy;
      end else begin
        x3 = span(-16000, 16000);
        y3 = span(-16000, 16000);
      end
      item = pack_lines(x1, y1, x1 + dx, y1 + dy, x3, y3, x3 + k * dx, y3 + k * dy);
    end else if (sel < 75) begin
      // Nearly parallel lines cross far away and often saturate.
      x1 = span(-16000, 16000);
      y1 = span(-16000, 16000);
      x3 = span(-16000, 16000);
      y3 = span(-16000, 16000);
      dx = span(-16000, 16000);
      dy = span(-16000, 16000);
      ex = dx;
      ey = dy;
      if ($urandom_range(0, 1) != 0) ex = ex + span(-1, 1);
      else ey = ey + span(-1, 1);
      item = pack_lines(x1, y1, x1 + dx, y1 + dy, x3, y3, x3 + ex, y3 + ey);
    end else if (sel < 85) begin
      item = {$urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 2) != 1) begin
        item.first_end_x = item.first_start_x;
        item.first_end_y = item.first_start_y;
      end
      if ($urandom_range(0, 2) != 0) begin
        item.second_end_x = item.second_start_x;
        item.second_end_y = item.second_start_y;
      end
    end else begin
      item = pack_lines(extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord(),
                        extreme_coord(), extreme_coord(), extreme_coord(), extreme_coord());
    end
    return item;
  endfunction

  task automatic send_lines(input llint_in_t item);
    while (!calm_phase() && $urandom_range(0, 99) < IDLE_PCT) begin
      lines_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    lines_ch.valid <= 1'b1;
    lines_ch.data  <= item;
    @(posedge clk_i);
    while (!lines_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    cross_ch.ready <= calm_phase() || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((lines_ch.valid && lines_ch.ready) || (cross_ch.valid && cross_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    lines_ch.valid <= 1'b0;
    lines_ch.data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both lines degenerate at the origin.
    send_lines(pack_lines(0, 0, 0, 0, 0, 0, 0, 0));
    // The two axes cross at the origin.
    send_lines(pack_lines(0, 0, 16, 0, 0, -16, 0, 16));
    send_lines(pack_lines(0, 0, 32, 32, 0, 32, 32, 0));
    // Parallel, then coincident.
    send_lines(pack_lines(0, 0, 16, 16, 0, 16, 16, 32));
    send_lines(pack_lines(0, 0, 16, 16, 32, 32, 48, 48));
    // One line collapsed to a point, on either side.
    send_lines(pack_lines(5, 5, 5, 5, 0, 0, 16, 16));
    send_lines(pack_lines(0, 0, 16, 16, -7, 9, -7, 9));
    send_lines(pack_lines(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_lines(pack_lines(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_lines(pack_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_lines(pack_lines(32767, -32768, -32768, 32767, 0, 0, 32767, 32767));
    // Determinant of minus one and plus one with far crossings: the first two saturate.
    send_lines(pack_lines(-32768, -32768, 32767, 32766, -32768, -32767, 32766, 32766));
    send_lines(pack_lines(-32768, 32767, 32767, -32767, -32768, 32766, 32766, -32767));
    send_lines(pack_lines(0, 0, 32767, 32766, 0, 1, 32766, 32766));
    // Fractional crossings check truncation toward zero on both signs.
    send_lines(pack_lines(0, 0, 3, 1, 1, 0, 1, 16));
    send_lines(pack_lines(0, 0, 3, -1, 1, 0, 1, 16));
    send_lines(pack_lines(0, 0, 3, -2, 2, 0, 2, 16));
    send_lines(pack_lines(0, 0, -3, 2, -2, 0, -2, -16));

    repeat (RANDOM_ITEMS) send_lines(random_lines());
    lines_ch.valid <= 1'b0;

    while (outstanding != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
